/* rtl/llds_pkg.sv */
package llds_pkg;

  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned VALUE_BITS_DEF = 32;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

endpackage

/* rtl/llds_ram.sv */
module llds_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/linked_list_deque_store_core.sv */
// Deque of signed values kept as a singly linked list in a pool of CAPACITY slots, with the
// free slots chained through the same link memory. Each request on the slave stream is one
// action (tuser: 0 push front, 1 push back, 2 pop front, 3 pop back, value in tdata) and
// gives exactly one result on the master stream: the popped value (zero on a push or a
// failed pop) in tdata and a status in tuser (0 ok, 1 full, 2 empty). One request is worked
// at a time; the link and value memories each have one synchronous read port. A rejected
// push or pop goes straight to the result, and a push back onto a non-empty list adds a step
// that links the old tail to the new slot. A pop back of a list with L entries walks the
// links from the head through the link memory, one link a cycle, to find the node before
// the tail. No clearing pass is needed after reset: slots at or above a high-water mark
// read as their initial free chain.
module linked_list_deque_store_core import llds_pkg::*; #(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic signed [DATA_W-1:0]   s_axis_tdata_i,   // [31:0] item_value
  input  logic [ACTION_W-1:0]        s_axis_tuser_i,   // [1:0] action
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic signed [DATA_W-1:0]   m_axis_tdata_o,   // [31:0] popped_value
  output logic [STATUS_W-1:0]        m_axis_tuser_o    // [1:0] status
);

  localparam int unsigned IW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam logic [IW-1:0] NIL = IW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_TAIL_LINK,
    S_GIVE,
    S_DONE
  } state_e;

  function automatic logic is_slot(logic [IW-1:0] x);
    return x < NIL;
  endfunction

  state_e                   state_q;
  action_e                  action_q;
  logic [VALUE_BITS-1:0]    value_q;
  logic [IW-1:0]            slot_q;
  logic [IW-1:0]            cur_q;
  logic [IW-1:0]            walk_cnt_q;
  logic [IW-1:0]            free_head_q;
  logic [IW-1:0]            head_q;
  logic [IW-1:0]            tail_q;
  logic [IW-1:0]            hwm_q;
  logic [IW-1:0]            rd_addr_q;
  logic signed [DATA_W-1:0] popped_q;
  status_e                  status_q;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_data_q;
  status_e                  out_status_q;

  logic                  in_accept;
  action_e               in_action;
  logic                  link_re, link_we, val_re, val_we;
  logic [IW-1:0]         link_raddr, link_waddr, link_wdata, val_raddr;
  logic [IW-1:0]         link_rdata, link_eff;
  logic [VALUE_BITS-1:0] val_rdata;
  logic signed [DATA_W-1:0] val_wide;
  logic                  walk_more;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign in_action       = action_e'(s_axis_tuser_i);

  // slots at or above the high-water mark were never taken and still link to the next one
  assign link_eff  = (rd_addr_q >= hwm_q) ? rd_addr_q + IW'(1) : link_rdata;
  assign val_wide  = DATA_W'(signed'(val_rdata));
  assign walk_more = is_slot(link_eff) && (link_eff != tail_q) && (walk_cnt_q < NIL);

  always_comb begin
    link_re    = 1'b0;
    link_raddr = head_q;
    val_re     = 1'b0;
    val_raddr  = head_q;
    link_we    = 1'b0;
    link_waddr = slot_q;
    link_wdata = free_head_q;
    val_we     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          unique case (in_action)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
              link_re    = is_slot(free_head_q);
              link_raddr = free_head_q;
            end
            ACT_POP_FRONT: begin
              link_re   = is_slot(head_q) && is_slot(tail_q);
              val_re    = link_re;
              val_raddr = head_q;
            end
            ACT_POP_BACK: begin
              link_re   = is_slot(head_q) && is_slot(tail_q);
              val_re    = link_re;
              val_raddr = tail_q;
            end
          endcase
        end
      end
      S_EXEC: begin
        unique case (action_q)
          ACT_PUSH_FRONT: begin
            link_we    = 1'b1;
            link_wdata = is_slot(head_q) ? head_q : NIL;
            val_we     = 1'b1;
          end
          ACT_PUSH_BACK: begin
            link_we    = 1'b1;
            link_wdata = NIL;
            val_we     = 1'b1;
          end
          ACT_POP_FRONT: begin
            link_we = 1'b1;
          end
          ACT_POP_BACK: begin
            if (head_q == tail_q) begin
              link_we = 1'b1;
            end else if (walk_more) begin
              link_re    = 1'b1;
              link_raddr = link_eff;
            end else begin
              link_we    = 1'b1;
              link_waddr = cur_q;
              link_wdata = NIL;
            end
          end
        endcase
      end
      S_WALK: begin
        if (walk_more) begin
          link_re    = 1'b1;
          link_raddr = link_eff;
        end else begin
          link_we    = 1'b1;
          link_waddr = cur_q;
          link_wdata = NIL;
        end
      end
      S_TAIL_LINK: begin
        link_we    = 1'b1;
        link_waddr = tail_q;
        link_wdata = slot_q;
      end
      S_GIVE: begin
        link_we = 1'b1;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  llds_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(IW)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (AW'(link_waddr)),
    .wdata_i (link_wdata),
    .re_i    (link_re),
    .raddr_i (AW'(link_raddr)),
    .rdata_o (link_rdata)
  );

  llds_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(VALUE_BITS)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (AW'(slot_q)),
    .wdata_i (value_q),
    .re_i    (val_re),
    .raddr_i (AW'(val_raddr)),
    .rdata_o (val_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      action_q     <= ACT_PUSH_FRONT;
      value_q      <= '0;
      slot_q       <= '0;
      cur_q        <= '0;
      walk_cnt_q   <= '0;
      free_head_q  <= '0;
      head_q       <= NIL;
      tail_q       <= NIL;
      hwm_q        <= '0;
      rd_addr_q    <= '0;
      popped_q     <= '0;
      status_q     <= ST_OK;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      out_status_q <= ST_OK;
    end else begin
      // in S_DONE the output register is handled below
      if (m_axis_tready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      if (link_re) begin
        rd_addr_q <= link_raddr;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            action_q   <= in_action;
            value_q    <= VALUE_BITS'(s_axis_tdata_i);
            cur_q      <= head_q;
            walk_cnt_q <= '0;
            popped_q   <= '0;
            status_q   <= ST_OK;
            unique case (in_action)
              ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                slot_q <= free_head_q;
                if (is_slot(free_head_q)) begin
                  state_q <= S_EXEC;
                end else begin
                  status_q <= ST_FULL;
                  state_q  <= S_DONE;
                end
              end
              ACT_POP_FRONT, ACT_POP_BACK: begin
                slot_q <= (in_action == ACT_POP_FRONT) ? head_q : tail_q;
                if (is_slot(head_q) && is_slot(tail_q)) begin
                  state_q <= S_EXEC;
                end else begin
                  status_q <= ST_EMPTY;
                  state_q  <= S_DONE;
                end
              end
            endcase
          end
        end
        S_EXEC: begin
          unique case (action_q)
            ACT_PUSH_FRONT: begin
              free_head_q <= link_eff;
              if (slot_q == hwm_q) begin
                hwm_q <= hwm_q + IW'(1);
              end
              head_q <= slot_q;
              if (!is_slot(tail_q)) begin
                tail_q <= slot_q;
              end
              state_q <= S_DONE;
            end
            ACT_PUSH_BACK: begin
              free_head_q <= link_eff;
              if (slot_q == hwm_q) begin
                hwm_q <= hwm_q + IW'(1);
              end
              if (is_slot(tail_q) && is_slot(head_q)) begin
                state_q <= S_TAIL_LINK;
              end else begin
                head_q  <= slot_q;
                tail_q  <= slot_q;
                state_q <= S_DONE;
              end
            end
            ACT_POP_FRONT: begin
              popped_q    <= val_wide;
              free_head_q <= slot_q;
              if (is_slot(link_eff)) begin
                head_q <= link_eff;
              end else begin
                head_q <= NIL;
                tail_q <= NIL;
              end
              state_q <= S_DONE;
            end
            ACT_POP_BACK: begin
              popped_q <= val_wide;
              if (head_q == tail_q) begin
                head_q      <= NIL;
                tail_q      <= NIL;
                free_head_q <= slot_q;
                state_q     <= S_DONE;
              end else if (walk_more) begin
                cur_q      <= link_eff;
                walk_cnt_q <= walk_cnt_q + IW'(1);
                state_q    <= S_WALK;
              end else begin
                tail_q  <= cur_q;
                state_q <= S_GIVE;
              end
            end
          endcase
        end
        S_WALK: begin
          if (walk_more) begin
            cur_q      <= link_eff;
            walk_cnt_q <= walk_cnt_q + IW'(1);
          end else begin
            tail_q  <= cur_q;
            state_q <= S_GIVE;
          end
        end
        S_TAIL_LINK: begin
          tail_q  <= slot_q;
          state_q <= S_DONE;
        end
        S_GIVE: begin
          free_head_q <= slot_q;
          state_q     <= S_DONE;
        end
        S_DONE: begin
          // wait here only while the previous result is still held by the sink
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q  <= 1'b1;
            out_data_q   <= popped_q;
            out_status_q <= status_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;

  a_hwm_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hwm_q <= NIL)
    else $error("high-water mark beyond pool size");

  a_free_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_head_q <= NIL)
    else $error("free head holds a stray index");

  a_head_tail_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_slot(head_q) == is_slot(tail_q))
    else $error("list head and tail disagree on emptiness");

  a_link_port_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(link_re && link_we))
    else $error("link memory read and written in the same cycle");

  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !s_axis_tready_o)
    else $error("request accepted while another is in progress");

endmodule

/* tb/sv/tb.sv */
module tb;
  import llds_pkg::*;

  localparam int unsigned CAP          = CAPACITY_DEF;
  localparam logic [4:0]  NIL          = 5'(CAPACITY_DEF);
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned DRAIN_CYCLES = CAPACITY_DEF + 8;

  typedef struct packed {
    action_e           act;
    logic [DATA_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic [DATA_W-1:0] popped;
    status_e           status;
  } outcome_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     s_axis_tvalid_i = 1'b0;
  logic                     s_axis_tready_o;
  logic signed [DATA_W-1:0] s_axis_tdata_i = '0;
  logic [ACTION_W-1:0]      s_axis_tuser_i = ACT_PUSH_FRONT;
  logic                     m_axis_tvalid_o;
  logic                     m_axis_tready_i = 1'b0;
  logic signed [DATA_W-1:0] m_axis_tdata_o;
  logic [STATUS_W-1:0]      m_axis_tuser_o;

  linked_list_deque_store_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),  // [31:0] item_value
    .s_axis_tuser_i  (s_axis_tuser_i),  // [1:0] action
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),  // [31:0] popped_value
    .m_axis_tuser_o  (m_axis_tuser_o)   // [1:0] status
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // shadow copy of the pool
  logic [DATA_W-1:0] value_mem [0:CAP-1];
  logic [4:0]        link_mem  [0:CAP-1];
  logic [4:0]        free_head;
  logic [4:0]        list_head;
  logic [4:0]        list_tail;

  request_t pending_requests[$];
  outcome_t expected_outcomes[$];

  int unsigned mismatches    = 0;
  int unsigned requests_sent = 0;
  int unsigned ok_seen       = 0;
  int unsigned full_seen     = 0;
  int unsigned empty_seen    = 0;
  int unsigned back_pops_ok  = 0;
  int unsigned cycles        = 0;

  function automatic outcome_t apply_action(action_e act, logic [DATA_W-1:0] val);
    outcome_t   r;
    logic [4:0] slot;
    logic [4:0] walk;
    int unsigned n;
    r.popped = '0;
    r.status = ST_OK;
    if (act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK) begin
      if (free_head >= NIL) begin
        r.status = ST_FULL;
      end else begin
        slot = free_head;
        free_head = link_mem[slot];
        value_mem[slot] = val;
        if (act == ACT_PUSH_FRONT) begin
          link_mem[slot] = (list_head < NIL) ? list_head : NIL;
          list_head = slot;
          if (list_tail >= NIL) list_tail = slot;
        end else begin
          link_mem[slot] = NIL;
          if (list_tail >= NIL || list_head >= NIL) begin
            list_head = slot;
            list_tail = slot;
          end else begin
            link_mem[list_tail] = slot;
            list_tail = slot;
          end
        end
      end
    end else if (list_head >= NIL || list_tail >= NIL) begin
      r.status = ST_EMPTY;
    end else if (act == ACT_POP_FRONT) begin
      slot = list_head;
      r.popped = value_mem[slot];
      list_head = link_mem[slot];
      if (list_head >= NIL) begin
        list_head = NIL;
        list_tail = NIL;
      end
      link_mem[slot] = free_head;
      free_head = slot;
    end else begin
      slot = list_tail;
      r.popped = value_mem[slot];
      if (list_head == list_tail) begin
        list_head = NIL;
        list_tail = NIL;
      end else begin
        // find the node just before the tail
        walk = list_head;
        n = 0;
        while (n < CAP && link_mem[walk] < NIL && link_mem[walk] != list_tail) begin
          walk = link_mem[walk];
          n++;
        end
        list_tail = walk;
        link_mem[walk] = NIL;
      end
      link_mem[slot] = free_head;
      free_head = slot;
    end
    return r;
  endfunction

  // sender: bursts of random length with random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    request_t req;
    outcome_t pred;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        req = pending_requests[0];
        pending_requests.delete(0);
        pred = apply_action(req.act, req.value);
        expected_outcomes = {expected_outcomes, pred};
        requests_sent++;
      end
      if (s_axis_tvalid_i && !s_axis_tready_o) begin
        // request not taken yet, hold it
      end else if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= pending_requests[0].value;
        s_axis_tuser_i  <= pending_requests[0].act;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches between always ready, coin flip and sparse
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 0;

  always @(posedge clk_i) begin
    outcome_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        case (m_axis_tuser_o)
          ST_OK:    ok_seen++;
          ST_FULL:  full_seen++;
          ST_EMPTY: empty_seen++;
          default:  ;
        endcase
        if (expected_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: data %h status %0d",
                     m_axis_tdata_o, m_axis_tuser_o);
        end else begin
          want = expected_outcomes[0];
          expected_outcomes.delete(0);
          if (m_axis_tdata_o !== want.popped || m_axis_tuser_o !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected data %h status %0d, got data %h status %0d",
                       want.popped, want.status, m_axis_tdata_o, m_axis_tuser_o);
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(10, 60);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       m_axis_tready_i <= 1'b1;
        1:       m_axis_tready_i <= $urandom_range(0, 1);
        default: m_axis_tready_i <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL linked_list_deque_store_core");
      $finish;
    end
  end

  task automatic add_request(action_e act, logic [DATA_W-1:0] val);
    request_t req;
    req.act = act;
    req.value = val;
    pending_requests = {pending_requests, req};
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || expected_outcomes.size() != 0 || s_axis_tvalid_i)
      @(negedge clk_i);
  endtask

  initial begin
    int unsigned      phase_left;
    bit               push_heavy;
    logic [DATA_W-1:0] val;
    int unsigned      i;
    for (i = 0; i < CAP; i++) link_mem[i] = 5'(i + 1);
    free_head = '0;
    list_head = NIL;
    list_tail = NIL;

    // empty pops, single-entry pops, fill to full, push when full, long back walk
    add_request(ACT_POP_FRONT, 32'h1234_5678);
    add_request(ACT_POP_BACK, 32'hFFFF_FFFF);
    add_request(ACT_PUSH_BACK, 32'h8000_0000);
    add_request(ACT_POP_BACK, 32'h0);
    add_request(ACT_PUSH_FRONT, 32'h7FFF_FFFF);
    add_request(ACT_POP_FRONT, 32'h0);
    for (i = 0; i < CAP; i++) begin
      case (i % 4)
        0:       val = 32'h0;
        1:       val = 32'hFFFF_FFFF;
        2:       val = 32'h5555_5555;
        default: val = 32'hAAAA_AAAA;
      endcase
      add_request((i % 2) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, val ^ i);
    end
    add_request(ACT_PUSH_BACK, 32'hDEAD_BEEF);
    add_request(ACT_POP_BACK, 32'h0);
    add_request(ACT_POP_FRONT, 32'h0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    wait_drained();

    // random phases lean to pushes or pops so the pool swings between full and empty
    phase_left = 0;
    push_heavy = 1'b1;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) wait_drained();
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 80);
        push_heavy = ~push_heavy;
      end
      phase_left--;
      case ($urandom_range(0, 7))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        2:       val = 32'hFFFF_FFFF;
        3:       val = 32'h0;
        default: val = $urandom;
      endcase
      if (($urandom_range(0, 99) < 70) == push_heavy)
        add_request($urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, val);
      else
        add_request($urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT, val);
    end

    @(negedge clk_i);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (expected_outcomes.size() != 0) mismatches++;

    $display("sent %0d requests over pushes and pops at both ends", requests_sent);
    $display("results seen: %0d ok, %0d full, %0d empty; %0d mismatches",
             ok_seen, full_seen, empty_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS linked_list_deque_store_core");
    end else begin
      $display("FAIL linked_list_deque_store_core");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/llds_pkg.sv
rtl/llds_ram.sv
rtl/linked_list_deque_store_core.sv
tb/sv/tb.sv
